@@ hdl/assert_macros.svh @@
// assert_macros.svh: concurrent assertion shorthands for the rasr checkers.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge out of reset.
`define RASR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RASR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rasr_pkg.sv @@
// rasr_pkg: widths, codes, job record and state types shared by the
// rational add/sub/reduce block. No dependencies.
`default_nettype none

package rasr_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int MAG_W        = 2 * OPERAND_BITS;
    localparam int NUM_W        = 32;
    localparam int DEN_W        = 30;
    localparam int EXT_W        = (MAG_W > NUM_W) ? MAG_W : NUM_W;
    localparam int CNT_W        = $clog2(MAG_W);
    localparam int K_W          = $clog2(MAG_W) + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    typedef logic [OPERAND_BITS-1:0] opmag_t;
    typedef logic [MAG_W-1:0]        mag_t;

    typedef enum logic [1:0] {
        REQ_NORM = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_SUB  = 2'd2,
        REQ_CMP  = 2'd3
    } req_t;

    // fixed: result needs no reduction (0/1, compare, error)
    typedef struct packed {
        logic fixed;
        logic neg;
        mag_t num;
        mag_t den;
        logic is_equal;
        logic status;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_MUL  = 2'd1,
        F_PUSH = 2'd2
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_GCD  = 2'd1,
        B_DIV  = 2'd2,
        B_OUT  = 2'd3
    } back_state_t;

endpackage

`default_nettype wire

@@ hdl/rasr_front.sv @@
// rasr_front: accepts a request beat, forms the cross products and
// classifies the item into a job record. Depends on rasr_pkg.
`default_nettype none

module rasr_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output logic                                        req_ready,
    input  wire logic [1:0]                             req_type,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_num,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_den,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] right_num,
    input  wire logic [rasr_pkg::OPERAND_BITS-2:0]      right_den,
    input  wire logic                                   full,
    output logic                                        push,
    output rasr_pkg::job_t                              job
);
    import rasr_pkg::*;

    front_state_t state_reg, state_next;
    req_t   op_reg;
    logic   ln_neg_reg, ld_neg_reg, rn_neg_reg;
    opmag_t ln_mag_reg, ld_mag_reg, rn_mag_reg;
    logic [OPERAND_BITS-2:0] rd_reg;
    mag_t   p_lr_reg, p_rl_reg, p_dd_reg;

    logic   accept;
    logic   den_eq;
    logic   num_neg, den_neg;
    mag_t   num_mag, den_mag;

    // sign-magnitude add, result {neg, mag}
    function automatic logic [MAG_W:0] sm_add(input logic an, input mag_t am,
                                              input logic bn, input mag_t bm);
        logic [MAG_W:0] r;
        if (an == bn)
            r = {an, am + bm};
        else if (am >= bm)
            r = {an, am - bm};
        else
            r = {bn, bm - am};
        return r;
    endfunction

    assign accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_MUL;
            F_MUL:  state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready = (state_reg == F_IDLE);
        push      = (state_reg == F_PUSH) && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req_t'(req_type);
            ln_neg_reg <= left_num[OPERAND_BITS-1];
            ln_mag_reg <= left_num[OPERAND_BITS-1] ? opmag_t'(~left_num) + opmag_t'(1)
                                                   : opmag_t'(left_num);
            ld_neg_reg <= left_den[OPERAND_BITS-1];
            ld_mag_reg <= left_den[OPERAND_BITS-1] ? opmag_t'(~left_den) + opmag_t'(1)
                                                   : opmag_t'(left_den);
            rn_neg_reg <= right_num[OPERAND_BITS-1] ^ (req_t'(req_type) == REQ_SUB);
            rn_mag_reg <= right_num[OPERAND_BITS-1] ? opmag_t'(~right_num) + opmag_t'(1)
                                                    : opmag_t'(right_num);
            rd_reg     <= right_den;
        end
        if (state_reg == F_MUL)
        begin
            p_lr_reg <= mag_t'(ln_mag_reg) * mag_t'(rd_reg);
            p_rl_reg <= mag_t'(rn_mag_reg) * mag_t'(ld_mag_reg);
            p_dd_reg <= mag_t'(ld_mag_reg) * mag_t'(rd_reg);
        end
    end

    // classification of the registered item
    always_comb
    begin
        den_eq = !ld_neg_reg && (ld_mag_reg == opmag_t'(rd_reg));
        if (op_reg == REQ_NORM || den_eq)
        begin
            if (op_reg == REQ_NORM)
                {num_neg, num_mag} = {ln_neg_reg, mag_t'(ln_mag_reg)};
            else
                {num_neg, num_mag} = sm_add(ln_neg_reg, mag_t'(ln_mag_reg),
                                            rn_neg_reg, mag_t'(rn_mag_reg));
            den_neg = ld_neg_reg;
            den_mag = mag_t'(ld_mag_reg);
        end
        else
        begin
            {num_neg, num_mag} = sm_add(ln_neg_reg, p_lr_reg,
                                        rn_neg_reg ^ ld_neg_reg, p_rl_reg);
            den_neg = ld_neg_reg;
            den_mag = p_dd_reg;
        end

        job.neg      = num_neg ^ den_neg;
        job.num      = num_mag;
        job.den      = den_mag;
        job.fixed    = 1'b1;
        job.is_equal = 1'b0;
        job.status   = 1'b0;
        if (op_reg == REQ_CMP)
            job.is_equal = den_eq && (ln_neg_reg == rn_neg_reg)
                           && (ln_mag_reg == rn_mag_reg);
        else if (num_mag == '0 && (op_reg == REQ_ADD || den_mag != '0))
            job.status = 1'b0;     // zero result, 0/1
        else if (den_mag == '0)
            job.status = 1'b1;     // zero denominator
        else
            job.fixed = 1'b0;
    end

endmodule

`default_nettype wire

@@ hdl/rasr_queue.sv @@
// rasr_queue: two-entry job queue between front and back.
// Depends on rasr_pkg.
`default_nettype none

module rasr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  rasr_pkg::job_t      job_in,
    output logic                full,
    input  wire logic           pop,
    output rasr_pkg::job_t      job_out,
    output logic                empty
);
    import rasr_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= job_in;
    end

endmodule

`default_nettype wire

@@ hdl/rasr_back.sv @@
// rasr_back: binary gcd, then two bit-serial divisions by the gcd, and the
// result register. Depends on rasr_pkg.
`default_nettype none

module rasr_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  rasr_pkg::job_t                    job,
    input  wire logic                         empty,
    output logic                              pop,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic signed [rasr_pkg::NUM_W-1:0] result_num,
    output logic [rasr_pkg::DEN_W-1:0]        result_den,
    output logic                              is_equal,
    output logic                              status
);
    import rasr_pkg::*;

    back_state_t state_reg, state_next;
    logic        neg_reg, phase_reg;
    mag_t        num_reg, den_reg, a_reg, b_reg, divisor_reg, rem_reg, quo_reg, nq_reg;
    logic [K_W-1:0]   k_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [NUM_W-1:0] result_num_reg;
    logic [DEN_W-1:0]        result_den_reg;
    logic                    is_equal_reg, status_reg;

    logic           gcd_done, div_last;
    logic [MAG_W:0] rem_sh;
    logic           ge;
    mag_t           rem_new, quo_new;
    logic [EXT_W-1:0] n_ext, n_signed, d_ext;

    assign gcd_done = (a_reg == b_reg);
    assign div_last = (cnt_reg == CNT_W'(MAG_W-1));

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[MAG_W-1]};
        ge       = rem_sh >= {1'b0, divisor_reg};
        rem_new  = ge ? mag_t'(rem_sh - {1'b0, divisor_reg}) : mag_t'(rem_sh);
        quo_new  = {quo_reg[MAG_W-2:0], ge};
        n_ext    = EXT_W'(nq_reg);
        n_signed = neg_reg ? (~n_ext + EXT_W'(1)) : n_ext;
        d_ext    = EXT_W'(quo_new);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!empty) state_next = job.fixed ? B_OUT : B_GCD;
            B_GCD:  if (gcd_done) state_next = B_DIV;
            B_DIV:  if (div_last && phase_reg) state_next = B_OUT;
            B_OUT:  if (res_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !empty;
        res_valid = (state_reg == B_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    neg_reg        <= job.neg;
                    num_reg        <= job.num;
                    den_reg        <= job.den;
                    a_reg          <= job.num;
                    b_reg          <= job.den;
                    k_reg          <= '0;
                    result_num_reg <= '0;
                    result_den_reg <= DEN_W'(1);
                    is_equal_reg   <= job.is_equal;
                    status_reg     <= job.status;
                end
            end
            B_GCD:
            begin
                if (gcd_done)
                begin
                    divisor_reg <= mag_t'(a_reg << k_reg);
                    rem_reg     <= '0;
                    quo_reg     <= num_reg;
                    cnt_reg     <= '0;
                    phase_reg   <= 1'b0;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_reg <= a_reg >> 1;
                    b_reg <= b_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!a_reg[0])
                    a_reg <= a_reg >> 1;
                else if (!b_reg[0])
                    b_reg <= b_reg >> 1;
                else if (a_reg > b_reg)
                    a_reg <= a_reg - b_reg;
                else
                    b_reg <= b_reg - a_reg;
            end
            B_DIV:
            begin
                if (div_last && !phase_reg)
                begin
                    // numerator done, start on the denominator
                    nq_reg    <= quo_new;
                    quo_reg   <= den_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    phase_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    rem_reg <= rem_new;
                    quo_reg <= quo_new;
                    if (div_last)
                    begin
                        result_num_reg <= n_signed[NUM_W-1:0];
                        result_den_reg <= d_ext[DEN_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign result_num = result_num_reg;
    assign result_den = result_den_reg;
    assign is_equal   = is_equal_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

@@ hdl/rational_add_sub_reduce.sv @@
// rational_add_sub_reduce: top level of the rational arithmetic unit.
// Depends on rasr_pkg, rasr_front, rasr_queue, rasr_back.
`default_nettype none

// Takes one request beat (normalize, add, subtract or compare of two
// fractions) and returns one result beat: a fraction reduced by the gcd of
// numerator and denominator magnitudes, with a positive denominator. A zero
// denominator is flagged before the reduction and, unless an add gives a
// zero numerator, gives status 1 and 0/1; compare gives is_equal with 0/1.
// The front stage takes a beat, forms the three cross products (16x15 and
// 16x16) in F_MUL and classifies the item into a job in F_PUSH, then drops
// it into a two-entry queue, so it can take the next beat while the back end
// is busy. The back end sets the rate: a binary gcd over 31-bit and 30-bit
// magnitudes (one shift or subtract per cycle) followed by two restoring
// divisions by the gcd, numerator first. Compare, zero results and
// zero-denominator errors skip the gcd and the divisions. A finished result
// waits in the output register until taken.
module rational_add_sub_reduce (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     req_valid,
    output logic                                          req_ready,
    input  wire logic [1:0]                               req_type,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_num,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_den,
    input  wire logic signed [rasr_pkg::OPERAND_BITS-1:0] right_num,
    input  wire logic [rasr_pkg::OPERAND_BITS-2:0]        right_den,
    output logic                                          res_valid,
    input  wire logic                                     res_ready,
    output logic signed [rasr_pkg::NUM_W-1:0]             result_num,
    output logic [rasr_pkg::DEN_W-1:0]                    result_den,
    output logic                                          is_equal,
    output logic                                          status
);
    import rasr_pkg::*;

    job_t front_job, queue_job;
    logic push, pop, full, empty;

    // front: capture, cross products, classification
    rasr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .left_num  (left_num),
        .left_den  (left_den),
        .right_num (right_num),
        .right_den (right_den),
        .full      (full),
        .push      (push),
        .job       (front_job)
    );

    // decoupling queue
    rasr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (front_job),
        .full    (full),
        .pop     (pop),
        .job_out (queue_job),
        .empty   (empty)
    );

    // back: gcd, divisions, result register
    rasr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (queue_job),
        .empty      (empty),
        .pop        (pop),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result_num (result_num),
        .result_den (result_den),
        .is_equal   (is_equal),
        .status     (status)
    );

endmodule

`default_nettype wire

@@ hdl/rasr_checker.sv @@
// rasr_checker: port-level assertions for rational_add_sub_reduce, bound to
// the top level. Depends on rasr_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module rasr_checker (
    input wire logic                                     clk,
    input wire logic                                     rst_n,
    input wire logic                                     req_valid,
    input wire logic                                     req_ready,
    input wire logic [1:0]                               req_type,
    input wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_num,
    input wire logic signed [rasr_pkg::OPERAND_BITS-1:0] left_den,
    input wire logic signed [rasr_pkg::OPERAND_BITS-1:0] right_num,
    input wire logic [rasr_pkg::OPERAND_BITS-2:0]        right_den,
    input wire logic                                     res_valid,
    input wire logic                                     res_ready,
    input wire logic signed [rasr_pkg::NUM_W-1:0]        result_num,
    input wire logic [rasr_pkg::DEN_W-1:0]               result_den,
    input wire logic                                     is_equal,
    input wire logic                                     status
);
    import rasr_pkg::*;

    `RASR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(result_num) && $stable(result_den) && $stable(status),
        "result beat changed while stalled")
    `RASR_ASSERT(a_den_nonzero, !res_valid || result_den != '0,
        "zero denominator on result")
    `RASR_ASSERT(a_err_zero, !(res_valid && status) ||
        (result_num == '0 && result_den == DEN_W'(1) && !is_equal),
        "error result is not 0/1")
    `RASR_ASSERT(a_eq_fixed, !(res_valid && is_equal) ||
        (result_num == '0 && result_den == DEN_W'(1) && !status),
        "compare result carries a fraction")

endmodule

bind rational_add_sub_reduce rasr_checker u_rasr_checker (.*);

`default_nettype wire
